>>> hdl/rtxl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtxl_pkg: shared types and constants of the RTP retransmit lookup unit
// Slot table geometry, field widths, result kinds and the table write request.
// ----------------------------------------------------------------------------
package rtxl_pkg;

    localparam int SLOTS    = 64;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int SEQ_W    = 16;
    localparam int LEN_W    = 16;
    localparam int TYPE_W   = 8;
    localparam int CTR_W    = 32;
    localparam int IDX_W    = 6;
    localparam int KIND_W   = 3;
    localparam int MSTEP_W  = $clog2(SEQ_W);
    localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    localparam logic [LEN_W-1:0]  MIN_STORE_LEN = 16'd12;
    localparam logic [LEN_W-1:0]  MAX_STORE_LEN = 16'd4096;
    localparam logic [LEN_W-1:0]  MIN_REQ_LEN   = 16'd8;
    localparam logic [TYPE_W-1:0] TYPE_MASK     = 8'h7f;
    localparam logic [TYPE_W-1:0] REQ_TYPE      = 8'h55;

    localparam logic OPC_STORE    = 1'b0;
    localparam logic OPC_DATAGRAM = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_STORED  = 3'd0,
        KIND_REJECT  = 3'd1,
        KIND_IGNORED = 3'd2,
        KIND_RESEND  = 3'd3,
        KIND_NO_HIT  = 3'd4
    } t_kind;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [SEQ_W-1:0]  tag;
    } t_tbl_wr;

endpackage : rtxl_pkg
`default_nettype wire

>>> hdl/rtxl_mod_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtxl_mod_unit: sequence to slot reduction
// Reduces a 16-bit sequence modulo SLOTS. A power-of-two table is a mask;
// otherwise a restoring shift-subtract step runs once per bit.
// ----------------------------------------------------------------------------
module rtxl_mod_unit
    import rtxl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SEQ_W-1:0]  i_value,
    output logic                   o_done,
    output logic [SLOT_W-1:0]      o_rem
);

    logic                r_run, n_run;
    logic                r_done, n_done;
    logic [MSTEP_W-1:0]  r_cnt, n_cnt;
    logic [SEQ_W-1:0]    r_val, n_val;
    logic [SLOT_W-1:0]   r_rem, n_rem;
    logic [SLOT_W:0]     trial;

    always_comb begin
        trial  = {r_rem, r_val[SEQ_W-1]};
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_val  = r_val;
        n_rem  = r_rem;
        if (i_start) begin
            n_val = i_value;
            n_cnt = MSTEP_W'(SEQ_W - 1);
            if (SLOTS_POW2) begin
                n_rem  = i_value[SLOT_W-1:0];
                n_done = 1'b1;
                n_run  = 1'b0;
            end else begin
                n_rem = '0;
                n_run = 1'b1;
            end
        end else if (r_run) begin
            if (trial >= (SLOT_W + 1)'(SLOTS)) begin
                trial = trial - (SLOT_W + 1)'(SLOTS);
            end
            n_rem = trial[SLOT_W-1:0];
            n_val = {r_val[SEQ_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_val <= n_val;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule : rtxl_mod_unit
`default_nettype wire

>>> hdl/rtxl_tag_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtxl_tag_table: slot tag memory with valid bits
// One write port and one registered read port. Valid bits clear on reset;
// tags stay undefined until written.
// ----------------------------------------------------------------------------
module rtxl_tag_table
    import rtxl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tbl_wr           i_wr,
    input  wire logic [SLOT_W-1:0] i_rd_addr,
    output logic                   o_rd_valid,
    output logic [SEQ_W-1:0]       o_rd_tag
);

    logic [SEQ_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    logic             r_rd_valid;
    logic [SEQ_W-1:0] r_rd_tag;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.tag;
        end
        r_rd_tag <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_tag   = r_rd_tag;

endmodule : rtxl_tag_table
`default_nettype wire

>>> hdl/rtp_retransmit_lookup_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_retransmit_lookup_unit: RTP sent-packet tag table and retransmit walker
// Stores sequence tags of sent packets and turns retransmit requests into
// resend descriptors for an external DMA engine.
// ----------------------------------------------------------------------------
// Timing: rejected stores and non-request datagrams return their single
// result in the cycle after start and leave busy low. A good store runs
// slot reduction (a mask for the 64-slot table), then the table write. A
// retransmit request runs slot reduction, one registered table read per
// requested sequence, and a final flush step for the last result. Results
// appear on o_valid for exactly one cycle and cannot be held off; a request
// issues at most one result per cycle.
// ----------------------------------------------------------------------------
module rtp_retransmit_lookup_unit
    import rtxl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_opcode,
    input  wire logic [SEQ_W-1:0]  i_item_sequence,
    input  wire logic [LEN_W-1:0]  i_item_length,
    input  wire logic [TYPE_W-1:0] i_type_byte,
    input  wire logic [SEQ_W-1:0]  i_first_wanted,
    input  wire logic [SEQ_W-1:0]  i_wanted_count,
    output logic                   o_valid,
    output logic [KIND_W-1:0]      o_kind,
    output logic [IDX_W-1:0]       o_slot_index,
    output logic [SEQ_W-1:0]       o_resend_sequence,
    output logic [SEQ_W-1:0]       o_echo_sequence,
    output logic                   o_last,
    output logic [CTR_W-1:0]       o_datagrams_seen,
    output logic [CTR_W-1:0]       o_requests_seen,
    output logic [CTR_W-1:0]       o_packets_resent
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MOD   = 4'b0010,
        S_CHECK = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic                r_is_store, n_is_store;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic [SEQ_W-1:0]    r_cur, n_cur;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]    r_left, n_left;
    logic                r_pend, n_pend;
    logic [SLOT_W-1:0]   r_pend_slot, n_pend_slot;
    logic [SEQ_W-1:0]    r_pend_seq, n_pend_seq;
    logic [CTR_W-1:0]    r_dgram, n_dgram;
    logic [CTR_W-1:0]    r_req, n_req;
    logic [CTR_W-1:0]    r_resent, n_resent;
    logic                r_valid, n_valid;
    t_kind               r_kind, n_kind;
    logic [IDX_W-1:0]    r_oslot, n_oslot;
    logic [SEQ_W-1:0]    r_oseq, n_oseq;
    logic [SEQ_W-1:0]    r_oecho, n_oecho;
    logic                r_olast, n_olast;

    logic                accept;
    logic                mod_start;
    logic [SEQ_W-1:0]    mod_value;
    logic                mod_done;
    logic [SLOT_W-1:0]   mod_rem;
    t_tbl_wr             tbl_wr;
    logic [SLOT_W-1:0]   rd_addr;
    logic                rd_valid;
    logic [SEQ_W-1:0]    rd_tag;
    logic                hit;
    logic [SLOT_W-1:0]   slot_adv;
    logic [SEQ_W-1:0]    wc;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    rtxl_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (mod_value),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    rtxl_tag_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_rd_addr  (rd_addr),
        .o_rd_valid (rd_valid),
        .o_rd_tag   (rd_tag)
    );

    assign hit      = rd_valid && (rd_tag == r_cur);
    assign slot_adv = ((r_cur == '1) || (r_slot == SLOT_W'(SLOTS - 1))) ? '0
                    : r_slot + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_is_store  = r_is_store;
        n_seq       = r_seq;
        n_cur       = r_cur;
        n_slot      = r_slot;
        n_left      = r_left;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_pend_seq  = r_pend_seq;
        n_dgram     = r_dgram;
        n_req       = r_req;
        n_resent    = r_resent;
        n_valid     = 1'b0;
        n_kind      = KIND_IGNORED;
        n_oslot     = '0;
        n_oseq      = '0;
        n_oecho     = '0;
        n_olast     = 1'b1;
        mod_start   = 1'b0;
        mod_value   = i_item_sequence;
        tbl_wr      = '0;
        rd_addr     = r_slot;
        wc          = i_wanted_count;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_seq      = i_item_sequence;
                    n_cur      = i_first_wanted;
                    n_is_store = (i_opcode == OPC_STORE);
                    if (wc == '0) begin
                        wc = SEQ_W'(1);
                    end else if (wc > SEQ_W'(SLOTS)) begin
                        wc = SEQ_W'(SLOTS);
                    end
                    n_left = wc[CNT_W-1:0];
                    if (i_opcode == OPC_STORE) begin
                        if (i_item_length < MIN_STORE_LEN
                                || i_item_length > MAX_STORE_LEN) begin
                            n_valid = 1'b1;
                            n_kind  = KIND_REJECT;
                        end else begin
                            mod_start = 1'b1;
                            n_state   = S_MOD;
                        end
                    end else if (i_item_length == '0) begin
                        n_valid = 1'b1;
                        n_kind  = KIND_IGNORED;
                    end else begin
                        n_dgram = r_dgram + 1'b1;
                        if (i_item_length < MIN_REQ_LEN
                                || (i_type_byte & TYPE_MASK) != REQ_TYPE) begin
                            n_valid = 1'b1;
                            n_kind  = KIND_IGNORED;
                        end else begin
                            n_req     = r_req + 1'b1;
                            mod_start = 1'b1;
                            mod_value = i_first_wanted;
                            n_pend    = 1'b0;
                            n_state   = S_MOD;
                        end
                    end
                end
            end
            S_MOD: begin
                rd_addr = mod_rem;
                if (mod_done) begin
                    n_slot = mod_rem;
                    if (r_is_store) begin
                        tbl_wr.en   = 1'b1;
                        tbl_wr.addr = mod_rem;
                        tbl_wr.tag  = r_seq;
                        n_valid     = 1'b1;
                        n_kind      = KIND_STORED;
                        n_oslot     = IDX_W'(mod_rem);
                        n_oseq      = r_seq;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                rd_addr = slot_adv;
                if (hit) begin
                    if (r_pend) begin
                        n_valid  = 1'b1;
                        n_kind   = KIND_RESEND;
                        n_oslot  = IDX_W'(r_pend_slot);
                        n_oseq   = r_pend_seq;
                        n_oecho  = r_seq;
                        n_olast  = 1'b0;
                        n_resent = r_resent + 1'b1;
                    end
                    n_pend      = 1'b1;
                    n_pend_slot = r_slot;
                    n_pend_seq  = r_cur;
                end
                if (r_left == CNT_W'(1)) begin
                    n_state = S_FLUSH;
                end else begin
                    n_left = r_left - 1'b1;
                    n_cur  = r_cur + 1'b1;
                    n_slot = slot_adv;
                end
            end
            S_FLUSH: begin
                n_valid = 1'b1;
                n_oecho = r_seq;
                if (r_pend) begin
                    n_kind   = KIND_RESEND;
                    n_oslot  = IDX_W'(r_pend_slot);
                    n_oseq   = r_pend_seq;
                    n_resent = r_resent + 1'b1;
                    n_pend   = 1'b0;
                end else begin
                    n_kind = KIND_NO_HIT;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_dgram  <= '0;
            r_req    <= '0;
            r_resent <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_dgram  <= n_dgram;
            r_req    <= n_req;
            r_resent <= n_resent;
            r_valid  <= n_valid;
        end
        r_is_store  <= n_is_store;
        r_seq       <= n_seq;
        r_cur       <= n_cur;
        r_slot      <= n_slot;
        r_left      <= n_left;
        r_pend_slot <= n_pend_slot;
        r_pend_seq  <= n_pend_seq;
        r_kind      <= n_kind;
        r_oslot     <= n_oslot;
        r_oseq      <= n_oseq;
        r_oecho     <= n_oecho;
        r_olast     <= n_olast;
    end

    assign o_valid           = r_valid;
    assign o_kind            = r_kind;
    assign o_slot_index      = r_oslot;
    assign o_resend_sequence = r_oseq;
    assign o_echo_sequence   = r_oecho;
    assign o_last            = r_olast;
    assign o_datagrams_seen  = r_dgram;
    assign o_requests_seen   = r_req;
    assign o_packets_resent  = r_resent;

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_STORED || o_kind == KIND_REJECT
            || o_kind == KIND_IGNORED || o_kind == KIND_NO_HIT) |-> o_last)
        else $error("single-result kind without last");

    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted request produced neither work nor result");

    a_resend_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_RESEND
            |-> o_packets_resent == CTR_W'($past(o_packets_resent) + 1'b1))
        else $error("resend result without counter bump");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("non-final result but walker went idle");

endmodule : rtp_retransmit_lookup_unit
`default_nettype wire
